// ===== src/latency_histogram_percentile_core_defines.svh =====
`ifndef LATENCY_HISTOGRAM_PERCENTILE_CORE_DEFINES_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define LHP_ASSERT_SAME(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("latency histogram check failed");

// Check that a condition implies another in the next cycle.
`define LHP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("latency histogram check failed");

`endif

// ===== src/lhp_pkg.sv =====
package lhp_pkg;

	localparam int NUM_REGS        = 7;
	localparam int BOUND_W         = 32;
	localparam int LAT_W           = 32;
	localparam int PCT_W           = 7;
	localparam int BIT_W           = 3;
	localparam int TOTAL_OUT_W     = 35;
	localparam int APB_ADDR_W      = 5;
	localparam int APB_DATA_W      = 32;
	localparam int REG_IDX_W       = 3;
	localparam int DEF_NUM_BOUNDS  = 7;
	localparam int DEF_COUNT_WIDTH = 32;

	localparam logic [TOTAL_OUT_W-1:0] TOTAL_OUT_MAX = '1;

	localparam logic [BOUND_W-1:0] BOUND_RESET [NUM_REGS] = '{
		32'd100, 32'd250, 32'd500, 32'd1000, 32'd2500, 32'd5000, 32'd10000
	};

	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef enum logic [1:0] {
		SAT_NONE,
		SAT_CNT,
		SAT_TOT
	} sat_mode_t;

	function automatic int total_width(input int cw);
		return (cw + 3 > 64) ? 64 : cw + 3;
	endfunction

endpackage

// ===== src/lhp_regs.sv =====
module lhp_regs
	import lhp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic [BOUND_W-1:0]    bound [NUM_REGS]
);

	logic [BOUND_W-1:0]   bound_q [NUM_REGS];
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[REG_IDX_W+1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				bound_q[i] <= BOUND_RESET[i];
			end
		end else if (wr_en) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (reg_idx == REG_IDX_W'(i)) begin
					bound_q[i] <= pwdata[BOUND_W-1:0];
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < NUM_REGS; i++) begin
			if (reg_idx == REG_IDX_W'(i)) begin
				prdata = APB_DATA_W'(bound_q[i]);
			end
		end
	end

	assign bound = bound_q;

endmodule

// ===== src/lhp_alu.sv =====
module lhp_alu
	import lhp_pkg::*;
#(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
	parameter int TOTAL_W     = total_width(DEF_COUNT_WIDTH),
	parameter int ALU_W       = total_width(DEF_COUNT_WIDTH) + PCT_W
) (
	input  logic [ALU_W-1:0] op_a,
	input  logic [ALU_W-1:0] op_b,
	input  sat_mode_t        sat,
	output logic [ALU_W-1:0] res
);

	logic [ALU_W:0] raw;

	assign raw = {1'b0, op_a} + {1'b0, op_b};

	always_comb begin
		case (sat)
			SAT_CNT: res = (|raw[ALU_W:COUNT_WIDTH]) ?
				ALU_W'({COUNT_WIDTH{1'b1}}) : raw[ALU_W-1:0];
			SAT_TOT: res = (|raw[ALU_W:TOTAL_W]) ?
				ALU_W'({TOTAL_W{1'b1}}) : raw[ALU_W-1:0];
			SAT_NONE: res = raw[ALU_W-1:0];
			default:  res = raw[ALU_W-1:0];
		endcase
	end

endmodule

// ===== src/lhp_seq.sv =====
module lhp_seq
	import lhp_pkg::*;
#(
	parameter int NUM_BOUNDS  = DEF_NUM_BOUNDS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   func,
	input  logic [LAT_W-1:0]       lat_sample,
	input  logic [PCT_W-1:0]       percent,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [BOUND_W-1:0]     pctl_bound,
	output logic [TOTAL_OUT_W-1:0] total_count,
	input  logic [BOUND_W-1:0]     bound [NUM_REGS]
);

	localparam int NUM_BUCKETS = NUM_BOUNDS + 1;
	localparam int IDX_W       = $clog2(NUM_BUCKETS);
	localparam int TOTAL_W     = total_width(COUNT_WIDTH);
	localparam int PROD_W      = TOTAL_W + PCT_W;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_REC_IDX  = 3'd1;
	localparam logic [2:0] ST_REC_INC  = 3'd2;
	localparam logic [2:0] ST_SUM      = 3'd3;
	localparam logic [2:0] ST_MUL      = 3'd4;
	localparam logic [2:0] ST_WALK_ADD = 3'd5;
	localparam logic [2:0] ST_WALK_CHK = 3'd6;
	localparam logic [2:0] ST_DONE     = 3'd7;

	logic [2:0]             state_q;
	logic [LAT_W-1:0]       lat_q;
	logic [PCT_W-1:0]       pct_q;
	logic [IDX_W-1:0]       idx_q;
	logic [BIT_W-1:0]       bit_q;
	logic [TOTAL_W-1:0]     total_q;
	logic [TOTAL_W-1:0]     seen_q;
	logic [PROD_W-1:0]      prod_q;
	logic [BOUND_W-1:0]     ans_q;
	logic [COUNT_WIDTH-1:0] counts_q [NUM_BUCKETS];
	logic                   out_valid_q;
	logic [BOUND_W-1:0]     out_pct_q;
	logic [TOTAL_OUT_W-1:0] out_tot_q;

	logic [COUNT_WIDTH-1:0] cnt_rd;
	logic [BOUND_W-1:0]     bound_sel;
	logic [BOUND_W-1:0]     last_bound;
	logic [IDX_W-1:0]       rec_idx;
	logic [PROD_W-1:0]      alu_a;
	logic [PROD_W-1:0]      alu_b;
	logic [PROD_W-1:0]      alu_y;
	sat_mode_t              alu_sat;
	logic [PROD_W-1:0]      seen_ext;
	logic [PROD_W-1:0]      seen100;
	logic                   hit;
	logic [63:0]            total64;
	logic                   out_load;
	logic                   last_idx;

	assign last_bound = bound[NUM_BOUNDS-1];
	assign last_idx   = (idx_q == IDX_W'(NUM_BUCKETS - 1));

	always_comb begin
		cnt_rd    = counts_q[0];
		bound_sel = last_bound;
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			if (idx_q == IDX_W'(i)) begin
				cnt_rd = counts_q[i];
			end
		end
		for (int i = 0; i < NUM_BOUNDS; i++) begin
			if (idx_q == IDX_W'(i)) begin
				bound_sel = bound[i];
			end
		end
	end

	always_comb begin
		rec_idx = IDX_W'(NUM_BOUNDS);
		for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
			if (lat_q <= bound[i]) begin
				rec_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sat = SAT_NONE;
		case (state_q)
			ST_REC_INC: begin
				alu_a   = PROD_W'(cnt_rd);
				alu_b   = PROD_W'(1);
				alu_sat = SAT_CNT;
			end
			ST_SUM: begin
				alu_a   = PROD_W'(total_q);
				alu_b   = PROD_W'(cnt_rd);
				alu_sat = SAT_TOT;
			end
			ST_MUL: begin
				alu_a   = prod_q;
				alu_b   = pct_q[bit_q] ? (PROD_W'(total_q) << bit_q) : '0;
				alu_sat = SAT_NONE;
			end
			ST_WALK_ADD: begin
				alu_a   = PROD_W'(seen_q);
				alu_b   = PROD_W'(cnt_rd);
				alu_sat = SAT_TOT;
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sat = SAT_NONE;
			end
		endcase
	end

	lhp_alu #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.TOTAL_W    (TOTAL_W),
		.ALU_W      (PROD_W)
	) u_alu (
		.op_a(alu_a),
		.op_b(alu_b),
		.sat (alu_sat),
		.res (alu_y)
	);

	assign seen_ext = PROD_W'(seen_q);
	assign seen100  = (seen_ext << 6) + (seen_ext << 5) + (seen_ext << 2);
	assign hit      = (seen_q != '0) && ((seen100 >= prod_q) || (&seen_q));
	assign total64  = 64'(total_q);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			bit_q   <= '0;
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						state_q <= (func == FUNC_QUERY) ? ST_SUM : ST_REC_IDX;
					end
				end
				ST_REC_IDX: begin
					idx_q   <= rec_idx;
					state_q <= ST_REC_INC;
				end
				ST_REC_INC: begin
					for (int i = 0; i < NUM_BUCKETS; i++) begin
						if (idx_q == IDX_W'(i)) begin
							counts_q[i] <= alu_y[COUNT_WIDTH-1:0];
						end
					end
					state_q <= ST_IDLE;
				end
				ST_SUM: begin
					if (last_idx) begin
						bit_q   <= '0;
						state_q <= ST_MUL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (bit_q == BIT_W'(PCT_W - 1)) begin
						idx_q   <= '0;
						state_q <= (total_q == '0) ? ST_DONE : ST_WALK_ADD;
					end else begin
						bit_q <= bit_q + 1'b1;
					end
				end
				ST_WALK_ADD: begin
					state_q <= ST_WALK_CHK;
				end
				ST_WALK_CHK: begin
					if (hit || last_idx) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_WALK_ADD;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lat_q   <= lat_sample;
				pct_q   <= percent;
				total_q <= '0;
			end
			ST_SUM: begin
				total_q <= alu_y[TOTAL_W-1:0];
				prod_q  <= '0;
			end
			ST_MUL: begin
				prod_q <= alu_y;
				seen_q <= '0;
				ans_q  <= (total_q == '0) ? '0 : last_bound;
			end
			ST_WALK_ADD: begin
				seen_q <= alu_y[TOTAL_W-1:0];
			end
			ST_WALK_CHK: begin
				if (hit) begin
					ans_q <= bound_sel;
				end
			end
			default: begin
				ans_q <= ans_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pct_q <= ans_q;
			out_tot_q <= (total64 > 64'(TOTAL_OUT_MAX)) ? TOTAL_OUT_MAX :
				total64[TOTAL_OUT_W-1:0];
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign pctl_bound  = out_pct_q;
	assign total_count = out_tot_q;

endmodule

// ===== src/latency_histogram_percentile_core.sv =====
// Latency histogram with percentile queries.
// Request channel: in_valid/in_stall with func, lat_sample and percent. func 0
// records a sample into the first bucket whose bound is not below it (or the
// overflow bucket); func 1 queries a percentile and yields one result.
// Result channel: out_valid/out_stall with pctl_bound and total_count.
// Bucket bounds sit in APB registers at byte addresses 0, 4 .. 24; write only
// while the block is idle. pready is tied high.
// One request is in work at a time; in_stall stays high meanwhile.
// Record: after acceptance, a bucket compare and then a counter increment
// through the shared adder come before the next acceptance.
// Query: the shared saturating adder sums NUM_BOUNDS+1 counters, builds
// percent*total in 7 shift-add steps, then walks the buckets with an add
// state and a check state each; the walk is skipped when all counts are 0.
// A finished result sits in an output register; while the receiver stalls,
// records are still taken, and a further query waits at its end for the slot.
// Reset clears all counters and restores the default bounds.
`include "latency_histogram_percentile_core_defines.svh"

module latency_histogram_percentile_core
	import lhp_pkg::*;
#(
	parameter int NUM_BOUNDS  = DEF_NUM_BOUNDS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   func,
	input  logic [LAT_W-1:0]       lat_sample,
	input  logic [PCT_W-1:0]       percent,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [BOUND_W-1:0]     pctl_bound,
	output logic [TOTAL_OUT_W-1:0] total_count,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	logic [BOUND_W-1:0] bound [NUM_REGS];

	assign pready = 1'b1;

	lhp_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.bound  (bound)
	);

	lhp_seq #(
		.NUM_BOUNDS (NUM_BOUNDS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.lat_sample (lat_sample),
		.percent    (percent),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pctl_bound (pctl_bound),
		.total_count(total_count),
		.bound      (bound)
	);

	`LHP_ASSERT_SAME(a_empty_answers_zero, clk, arst_n,
		$rose(out_valid) && (total_count == '0), pctl_bound == '0)
	`LHP_ASSERT_NEXT(a_record_no_result, clk, arst_n,
		in_valid && !in_stall && (func == FUNC_RECORD), !$rose(out_valid))
	`LHP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

endmodule

// ===== bench/testbench.sv =====
module testbench
	import lhp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BUCKETS   = DEF_NUM_BOUNDS + 1;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 4000;

	typedef struct packed {
		logic [BOUND_W-1:0]     percentile;
		logic [TOTAL_OUT_W-1:0] total;
	} query_answer_t;

	typedef enum {BOUNDS_ASCENDING, BOUNDS_WILD, BOUNDS_DEFAULT} bound_plan_t;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   in_valid   = 1'b0;
	logic                   in_stall;
	logic                   func       = FUNC_RECORD;
	logic [LAT_W-1:0]       lat_sample = '0;
	logic [PCT_W-1:0]       percent    = '0;
	logic                   out_valid;
	logic                   out_stall  = 1'b0;
	logic [BOUND_W-1:0]     pctl_bound;
	logic [TOTAL_OUT_W-1:0] total_count;
	logic                   psel       = 1'b0;
	logic                   penable    = 1'b0;
	logic                   pwrite     = 1'b0;
	logic [APB_ADDR_W-1:0]  paddr      = '0;
	logic [APB_DATA_W-1:0]  pwdata     = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	logic [BOUND_W-1:0]         bound_copy [NUM_REGS];
	logic [DEF_COUNT_WIDTH-1:0] bucket_tally [NUM_BUCKETS];
	query_answer_t              pending_answers [$];

	int          error_count       = 0;
	int          stalled_cycles    = 0;
	int unsigned sender_idle_pct   = 0;
	int unsigned receiver_idle_pct = 0;

	latency_histogram_percentile_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.lat_sample    (lat_sample),
		.percent       (percent),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pctl_bound    (pctl_bound),
		.total_count   (total_count),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void tally_latency(input logic [LAT_W-1:0] lat);
		int b;
		b = 0;
		while (b < DEF_NUM_BOUNDS && lat > bound_copy[b])
			b++;
		if (bucket_tally[b] != {DEF_COUNT_WIDTH{1'b1}})
			bucket_tally[b]++;
	endfunction

	function automatic query_answer_t predict_query(input logic [PCT_W-1:0] pct);
		logic [63:0]   total;
		logic [63:0]   seen;
		logic [63:0]   target;
		query_answer_t ans;
		total = '0;
		seen  = '0;
		for (int i = 0; i < NUM_BUCKETS; i++)
			total += 64'(bucket_tally[i]);
		ans.total = (total > 64'(TOTAL_OUT_MAX)) ? TOTAL_OUT_MAX : total[TOTAL_OUT_W-1:0];
		if (total == 0) begin
			ans.percentile = '0;
			return ans;
		end
		target = (64'(pct) * total + 64'd99) / 64'd100;
		ans.percentile = bound_copy[DEF_NUM_BOUNDS-1];
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			seen += 64'(bucket_tally[i]);
			if (seen >= target && seen != 0) begin
				ans.percentile = (i < DEF_NUM_BOUNDS) ? bound_copy[i] : bound_copy[DEF_NUM_BOUNDS-1];
				break;
			end
		end
		return ans;
	endfunction

	function automatic logic [LAT_W-1:0] pick_latency();
		logic [BOUND_W-1:0] edge_bound;
		edge_bound = bound_copy[$urandom_range(NUM_REGS-1)];
		case ($urandom_range(4))
			0: return $urandom();
			1: return LAT_W'($urandom_range(12000));
			2: return edge_bound + LAT_W'($urandom_range(2)) - LAT_W'(1);
			3: return $urandom_range(1) ? {LAT_W{1'b1}} : {LAT_W{1'b0}};
			default: return edge_bound;
		endcase
	endfunction

	task automatic send_request(input logic f, input logic [LAT_W-1:0] lat,
			input logic [PCT_W-1:0] pct);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		lat_sample <= lat;
		percent    <= pct;
		do @(posedge clk); while (in_stall);
		if (f == FUNC_QUERY)
			pending_answers.push_back(predict_query(pct));
		else
			tally_latency(lat);
	endtask

	task automatic write_bound(input int idx, input logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(4 * idx);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx < NUM_REGS)
			bound_copy[idx] = value;
	endtask

	// drain results and let a trailing record finish
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_empty_and_defaults();
		logic [LAT_W-1:0] samples [8];
		logic [PCT_W-1:0] ranks [7];
		samples = '{32'd0, 32'd100, 32'd101, 32'd250, 32'd10000, 32'd10001,
			32'hFFFF_FFFF, 32'd5000};
		ranks = '{7'd0, 7'd1, 7'd50, 7'd99, 7'd100, 7'd101, 7'd127};
		send_request(FUNC_QUERY, '0, 7'd50);
		send_request(FUNC_QUERY, '1, 7'd0);
		send_request(FUNC_QUERY, '0, 7'd127);
		foreach (samples[i])
			send_request(FUNC_RECORD, samples[i], 7'h7F);
		foreach (ranks[i])
			send_request(FUNC_QUERY, $urandom(), ranks[i]);
	endtask

	task automatic test_unordered_bounds();
		logic [BOUND_W-1:0] plan [NUM_REGS];
		plan = '{32'd0, 32'hFFFF_FFFF, 32'd7, 32'd7, 32'd1000, 32'd3, 32'hFFFF_FFFE};
		settle_block();
		foreach (plan[i])
			write_bound(i, plan[i]);
		write_bound(NUM_REGS, $urandom());
		send_request(FUNC_RECORD, 32'd0, 7'd0);
		send_request(FUNC_RECORD, 32'd1, 7'd100);
		send_request(FUNC_RECORD, 32'd7, 7'd50);
		send_request(FUNC_RECORD, 32'hFFFF_FFFF, 7'd127);
		send_request(FUNC_QUERY, 32'd0, 7'd0);
		send_request(FUNC_QUERY, 32'hFFFF_FFFF, 7'd50);
		send_request(FUNC_QUERY, 32'd0, 7'd100);
		send_request(FUNC_QUERY, 32'd0, 7'd127);
	endtask

	task automatic test_random_traffic(input int items, input int unsigned send_idle,
			input int unsigned recv_idle, input bound_plan_t plan);
		logic [BOUND_W-1:0] level;
		logic               f;
		logic [PCT_W-1:0]   pct;
		settle_block();
		level = '0;
		for (int i = 0; i < NUM_REGS; i++) begin
			case (plan)
				BOUNDS_ASCENDING: begin
					level += BOUND_W'($urandom_range(3000, 1));
					write_bound(i, level);
				end
				BOUNDS_WILD: begin
					case ($urandom_range(3))
						0: write_bound(i, '0);
						1: write_bound(i, '1);
						2: write_bound(i, $urandom());
						default: write_bound(i, $urandom_range(20000));
					endcase
				end
				default: write_bound(i, BOUND_RESET[i]);
			endcase
		end
		sender_idle_pct   = send_idle;
		receiver_idle_pct = recv_idle;
		repeat (items) begin
			f   = ($urandom_range(99) < 25) ? FUNC_QUERY : FUNC_RECORD;
			pct = ($urandom_range(7) == 0) ? PCT_W'($urandom_range(127, 101))
				: PCT_W'($urandom_range(100));
			send_request(f, pick_latency(), pct);
		end
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	always @(posedge clk) begin
		query_answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result pctl_bound=%0d total_count=%0d",
					$time, pctl_bound, total_count);
			end else begin
				want = pending_answers.pop_front();
				if (pctl_bound !== want.percentile) begin
					error_count++;
					$display("%0t: pctl_bound expected %0d actual %0d",
						$time, want.percentile, pctl_bound);
				end
				if (total_count !== want.total) begin
					error_count++;
					$display("%0t: total_count expected %0d actual %0d",
						$time, want.total, total_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		bound_copy = BOUND_RESET;
		foreach (bucket_tally[i])
			bucket_tally[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_defaults();
		test_unordered_bounds();
		test_random_traffic(475, 20, 52, BOUNDS_ASCENDING);
		test_random_traffic(475, 52, 20, BOUNDS_WILD);
		test_random_traffic(475, 0, 0, BOUNDS_DEFAULT);
		settle_block();
		if (error_count == 0 && pending_answers.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== latency_histogram_percentile_core.f =====
+incdir+src
src/lhp_pkg.sv
src/lhp_regs.sv
src/lhp_alu.sv
src/lhp_seq.sv
src/latency_histogram_percentile_core.sv
bench/testbench.sv
